/* rtl/adhp_pkg.sv */
// Package for the ASCII decimal/hex number parser.
// Holds the phase codes, the scan state and result records, and character helpers.
// No dependencies.
`default_nettype none

package adhp_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int CHAR_WIDTH  = 8;

   localparam logic [CHAR_WIDTH-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LF      = 8'h0A;
   localparam logic [CHAR_WIDTH-1:0] CHAR_CR      = 8'h0D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_X = 8'h58;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_X = 8'h78;

   typedef enum logic [4:0] {
      PH_SKIP   = 5'b00001,
      PH_ZERO   = 5'b00010,
      PH_DIGITS = 5'b00100,
      PH_DONE   = 5'b01000,
      PH_FAIL   = 5'b10000
   } phase_type;

   typedef struct packed {
      phase_type              phase;
      logic                   hex_mode;
      logic [VALUE_WIDTH-1:0] accumulator;
      logic                   seen_digit;
   } scan_state_type;

   typedef struct packed {
      logic                   ok;
      logic [VALUE_WIDTH-1:0] value;
   } result_type;

   localparam scan_state_type SCAN_RESET = '{
      phase:       PH_SKIP,
      hex_mode:    1'b0,
      accumulator: '0,
      seen_digit:  1'b0
   };

   function automatic logic is_white_char(input logic [CHAR_WIDTH-1:0] ch);
      return ch inside {CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF};
   endfunction

   function automatic logic is_dec_digit(input logic [CHAR_WIDTH-1:0] ch);
      return ch inside {[CHAR_ZERO:CHAR_NINE]};
   endfunction

   function automatic logic is_hex_letter(input logic [CHAR_WIDTH-1:0] ch);
      return ch inside {[CHAR_UPPER_A:CHAR_UPPER_F], [CHAR_LOWER_A:CHAR_LOWER_F]};
   endfunction

   // Digits carry their value in the low nibble; letters A-F / a-f have 1..6 there.
   function automatic logic [3:0] digit_value(input logic [CHAR_WIDTH-1:0] ch);
      return is_dec_digit(ch) ? ch[3:0] : 4'(ch[3:0] + 4'd9);
   endfunction

endpackage

`default_nettype wire

/* rtl/adhp_if.sv */
// Valid/ready channel interfaces for the number parser.
// Depends on adhp_pkg for field widths.
`default_nettype none

interface adhp_req_if;
   logic                               valid;
   logic                               ready;
   logic [adhp_pkg::CHAR_WIDTH-1:0]    character;

   modport source (output valid, output character, input ready);
   modport sink   (input valid, input character, output ready);
endinterface

interface adhp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 ok;
   logic signed [adhp_pkg::VALUE_WIDTH-1:0] value;

   modport source (output valid, output ok, output value, input ready);
   modport sink   (input valid, input ok, input value, output ready);
endinterface

`default_nettype wire

/* rtl/adhp_step.sv */
// Next-state and result logic for one character of the number parser.
// Purely combinational; depends on adhp_pkg.
`default_nettype none

module adhp_step (
   input  wire adhp_pkg::scan_state_type          cur,
   input  wire logic [adhp_pkg::CHAR_WIDTH-1:0]   character,
   output adhp_pkg::scan_state_type               nxt,
   output logic                                   emit,
   output adhp_pkg::result_type                   result
);

   logic                                 eff_hex;
   logic [adhp_pkg::VALUE_WIDTH-1:0]     eff_acc;
   logic                                 eff_seen;
   logic                                 run_digit;
   logic                                 digit_ok;
   logic [adhp_pkg::VALUE_WIDTH-1:0]     scaled;
   logic                                 ws;

   always_comb begin
      ws        = adhp_pkg::is_white_char(character);
      eff_hex   = cur.hex_mode;
      eff_acc   = cur.accumulator;
      eff_seen  = cur.seen_digit;
      run_digit = 1'b0;
      nxt       = cur;
      emit      = 1'b0;
      result    = '0;

      if (character == adhp_pkg::CHAR_NUL) begin
         // end of string: report and rearm
         emit = 1'b1;
         if (cur.phase == adhp_pkg::PH_ZERO) begin
            result.ok = 1'b1;
         end else if ((cur.phase == adhp_pkg::PH_DIGITS && cur.seen_digit) ||
                      cur.phase == adhp_pkg::PH_DONE) begin
            result.ok    = 1'b1;
            result.value = cur.accumulator;
         end
         nxt = adhp_pkg::SCAN_RESET;
      end else begin
         case (cur.phase)
            adhp_pkg::PH_SKIP: begin
               if (ws) begin
                  nxt = cur;
               end else if (character == adhp_pkg::CHAR_ZERO) begin
                  nxt.phase = adhp_pkg::PH_ZERO;
               end else begin
                  eff_hex   = 1'b0;
                  eff_acc   = '0;
                  eff_seen  = 1'b0;
                  run_digit = 1'b1;
               end
            end
            adhp_pkg::PH_ZERO: begin
               if (character == adhp_pkg::CHAR_LOWER_X ||
                   character == adhp_pkg::CHAR_UPPER_X) begin
                  nxt.phase       = adhp_pkg::PH_DIGITS;
                  nxt.hex_mode    = 1'b1;
                  nxt.accumulator = '0;
                  nxt.seen_digit  = 1'b0;
               end else begin
                  // the leading zero counts as a decimal digit
                  eff_hex   = 1'b0;
                  eff_acc   = '0;
                  eff_seen  = 1'b1;
                  run_digit = 1'b1;
               end
            end
            adhp_pkg::PH_DIGITS: begin
               run_digit = 1'b1;
            end
            default: begin
               nxt = cur;
            end
         endcase
      end

      digit_ok = adhp_pkg::is_dec_digit(character) ||
                 (eff_hex && adhp_pkg::is_hex_letter(character));
      scaled   = eff_hex ? {eff_acc[27:0], 4'b0000}
                         : ({eff_acc[28:0], 3'b000} + {eff_acc[30:0], 1'b0});

      if (run_digit) begin
         nxt.hex_mode    = eff_hex;
         nxt.accumulator = eff_acc;
         nxt.seen_digit  = eff_seen;
         if (ws && eff_seen) begin
            nxt.phase = adhp_pkg::PH_DONE;
         end else if (digit_ok) begin
            nxt.phase       = adhp_pkg::PH_DIGITS;
            nxt.accumulator = scaled +
                              {{(adhp_pkg::VALUE_WIDTH-4){1'b0}},
                               adhp_pkg::digit_value(character)};
            nxt.seen_digit  = 1'b1;
         end else begin
            nxt.phase = adhp_pkg::PH_FAIL;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/adhp_rsp_reg.sv */
// Result register driving the response channel of the number parser.
// Depends on adhp_pkg and adhp_rsp_if.
`default_nettype none

module adhp_rsp_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire adhp_pkg::result_type  load_data,
   output logic                       free,
   adhp_rsp_if.source                 rsp
);

   logic                  valid_ff;
   logic                  valid_in;
   adhp_pkg::result_type  data_ff;

   assign free     = !valid_ff || rsp.ready;
   assign valid_in = load ? 1'b1 : (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp.valid = valid_ff;
   assign rsp.ok    = data_ff.ok;
   assign rsp.value = $signed(data_ff.value);

endmodule

`default_nettype wire

/* rtl/ascii_dec_hex_number_parser.sv */
// Top level of the ASCII decimal/hex number parser.
// Instantiates adhp_step and adhp_rsp_reg; depends on adhp_pkg and adhp_if.
//
// The parser takes one ASCII character per word on req_chan and accepts a new
// word every cycle unless a held response stalls it, so a string and its zero
// terminator stream in back to back. Leading space, tab, CR and LF are
// skipped; a leading 0x or 0X selects hexadecimal (either letter case),
// otherwise the number is decimal. Digits build value*base+digit, wrapping
// modulo 2^32. Whitespace after a digit ends the number and the rest of the
// string is ignored; any character outside the base fails the string. Only
// the zero byte produces a word on rsp_chan, in the cycle after it is accepted,
// carrying ok and value (value is zero when ok is low); the parser then
// rearms for the next string. The combinational next-state path (one shift-add
// for the base multiply plus the digit add) bounds the clock. While a held
// response is blocked by rsp_chan.ready, req_chan stalls, whatever the
// incoming character; as soon as the response leaves, input resumes in the
// same cycle.
`default_nettype none

module ascii_dec_hex_number_parser (
   input  wire logic   clock,
   input  wire logic   reset,
   adhp_req_if.sink    req_chan,
   adhp_rsp_if.source  rsp_chan
);

   adhp_pkg::scan_state_type  state_ff;
   adhp_pkg::scan_state_type  state_in;
   adhp_pkg::result_type      step_result;
   logic                      step_emit;
   logic                      rsp_free;
   logic                      req_accept;

   // accept whenever the result register can take a response this cycle
   assign req_chan.ready = rsp_free;
   assign req_accept     = req_chan.valid && rsp_free;

   adhp_step u_step (
      .cur       (state_ff),
      .character (req_chan.character),
      .nxt       (state_in),
      .emit      (step_emit),
      .result    (step_result)
   );

   // advance the scan state on every accepted word, hold otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= adhp_pkg::SCAN_RESET;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   adhp_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept && step_emit),
      .load_data (step_result),
      .free      (rsp_free),
      .rsp       (rsp_chan)
   );

   // a terminator shows up as a response on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_chan.character == adhp_pkg::CHAR_NUL |=> rsp_chan.valid)
      else $error("terminator did not produce a response");

   // a terminator rearms the scanner
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_chan.character == adhp_pkg::CHAR_NUL |=>
         state_ff == adhp_pkg::SCAN_RESET)
      else $error("scanner not rearmed after terminator");

   // a failed parse reports zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ok |-> rsp_chan.value == '0)
      else $error("nonzero value with ok low");

   // input only stalls behind a held response
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid && !rsp_chan.ready)
      else $error("input stalled without a blocked response");

endmodule

`default_nettype wire
